>>> hw/rtl/bhsnl_pkg.sv
package bhsnl_pkg;

    // Default coordinate width
    localparam int COORD_BITS_DEF = 15;

    // Decision flags from the hit/select logic to the top level
    typedef struct packed {
        logic hit;   // box holds the midpoint
        logic take;  // box replaces the running choice
    } sel_ctl_t;

endpackage

>>> hw/rtl/bhsnl_select.sv
module bhsnl_select #(
    parameter int COORD_BITS = bhsnl_pkg::COORD_BITS_DEF
) (
    input  logic [COORD_BITS-1:0] center_x,
    input  logic [COORD_BITS-1:0] center_y,
    input  logic [COORD_BITS-1:0] anchor_x,
    input  logic                  have_best,
    input  logic [COORD_BITS-1:0] best_left,
    input  logic                  present,
    input  logic [COORD_BITS-1:0] box_left,
    input  logic [COORD_BITS-1:0] box_top,
    input  logic [COORD_BITS-1:0] box_right,
    input  logic [COORD_BITS-1:0] box_bottom,
    output bhsnl_pkg::sel_ctl_t   ctl
);

    logic kept_neg;   // anchor - kept.left < 0
    logic new_neg;    // anchor - new.left < 0
    logic new_closer; // new distance <= kept distance

    // Containment test, bounds included
    always_comb
    begin
        ctl.hit = present
                  && (box_left <= center_x) && (box_right >= center_x)
                  && (box_top <= center_y) && (box_bottom >= center_y);
    end

    // Nearest-left choice; with both distances non-negative,
    // dk >= dn reduces to kept.left <= new.left (tie goes to the later box)
    always_comb
    begin
        kept_neg   = anchor_x < best_left;
        new_neg    = anchor_x < box_left;
        new_closer = best_left <= box_left;
        ctl.take   = ctl.hit && (!have_best || kept_neg || (!new_neg && new_closer));
    end

endmodule

>>> hw/rtl/box_hit_select_nearest_left_top.sv
// Channel  | Handshake            | Payload
// ---------+----------------------+------------------------------------------
// request  | req_valid, req_stall | point_a/b_x/y, rect_*, rect_present, last_rect
// response | rsp_valid, rsp_stall | found, sel_left/top/right/bottom
//
// One request per cycle sustained while req_stall is low; the response for a list
// follows its last request through the input register, then the result register.
// The midpoint adder sits before the input register; the hit compares and the
// nearest-left choice sit between the input and result registers.
// Reset (rst_n low, asynchronous) empties both stages and starts a new list.
// A stalled response holds the result stage; the input stage then holds a
// last request and req_stall rises, while non-last requests keep flowing.
module box_hit_select_nearest_left_top #(
    parameter int COORD_BITS = bhsnl_pkg::COORD_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_stall,
    input  logic [COORD_BITS-1:0] point_a_x,
    input  logic [COORD_BITS-1:0] point_a_y,
    input  logic [COORD_BITS-1:0] point_b_x,
    input  logic [COORD_BITS-1:0] point_b_y,
    input  logic [COORD_BITS-1:0] rect_left,
    input  logic [COORD_BITS-1:0] rect_top,
    input  logic [COORD_BITS-1:0] rect_right,
    input  logic [COORD_BITS-1:0] rect_bottom,
    input  logic                  rect_present,
    input  logic                  last_rect,
    output logic                  rsp_valid,
    input  logic                  rsp_stall,
    output logic                  found,
    output logic [COORD_BITS-1:0] sel_left,
    output logic [COORD_BITS-1:0] sel_top,
    output logic [COORD_BITS-1:0] sel_right,
    output logic [COORD_BITS-1:0] sel_bottom
);

    // Input stage
    logic                  s1_valid_reg;
    logic [COORD_BITS-1:0] s1_cx_reg, s1_cy_reg, s1_ax_reg;
    logic [COORD_BITS-1:0] s1_left_reg, s1_top_reg, s1_right_reg, s1_bottom_reg;
    logic                  s1_present_reg, s1_last_reg;

    // List state
    logic                  mid_list_reg;
    logic [COORD_BITS-1:0] center_x_reg, center_y_reg, anchor_x_reg;
    logic                  have_best_reg;
    logic [COORD_BITS-1:0] best_left_reg, best_top_reg, best_right_reg, best_bottom_reg;

    // Result stage
    logic                  rsp_valid_reg;
    logic                  found_reg;
    logic [COORD_BITS-1:0] sel_left_reg, sel_top_reg, sel_right_reg, sel_bottom_reg;

    logic                  rsp_load;
    logic                  s1_adv;
    logic                  s1_load;
    logic [COORD_BITS:0]   sum_x, sum_y;
    logic [COORD_BITS-1:0] eff_cx, eff_cy, eff_ax;
    logic                  eff_have;
    bhsnl_pkg::sel_ctl_t   ctl;
    logic                  have_next;
    logic [COORD_BITS-1:0] best_left_next, best_top_next, best_right_next, best_bottom_next;

    // Handshake control
    assign rsp_load  = !rsp_valid_reg || !rsp_stall;
    assign s1_adv    = s1_valid_reg && (!s1_last_reg || rsp_load);
    assign s1_load   = req_valid && (!s1_valid_reg || s1_adv);
    assign req_stall = s1_valid_reg && !s1_adv;

    // Midpoint, halves rounded down
    assign sum_x = {1'b0, point_a_x} + {1'b0, point_b_x};
    assign sum_y = {1'b0, point_a_y} + {1'b0, point_b_y};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_load || s1_adv)
        begin
            s1_valid_reg <= s1_load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_cx_reg      <= sum_x[COORD_BITS:1];
            s1_cy_reg      <= sum_y[COORD_BITS:1];
            s1_ax_reg      <= point_a_x;
            s1_left_reg    <= rect_left;
            s1_top_reg     <= rect_top;
            s1_right_reg   <= rect_right;
            s1_bottom_reg  <= rect_bottom;
            s1_present_reg <= rect_present;
            s1_last_reg    <= last_rect;
        end
    end

    // First request of a list supplies the points
    assign eff_cx   = mid_list_reg ? center_x_reg : s1_cx_reg;
    assign eff_cy   = mid_list_reg ? center_y_reg : s1_cy_reg;
    assign eff_ax   = mid_list_reg ? anchor_x_reg : s1_ax_reg;
    assign eff_have = mid_list_reg && have_best_reg;

    bhsnl_select #(
        .COORD_BITS(COORD_BITS)
    ) u_select (
        .center_x  (eff_cx),
        .center_y  (eff_cy),
        .anchor_x  (eff_ax),
        .have_best (eff_have),
        .best_left (best_left_reg),
        .present   (s1_present_reg),
        .box_left  (s1_left_reg),
        .box_top   (s1_top_reg),
        .box_right (s1_right_reg),
        .box_bottom(s1_bottom_reg),
        .ctl       (ctl)
    );

    // Running choice update
    always_comb
    begin
        have_next = eff_have || ctl.take;
        if (ctl.take)
        begin
            best_left_next   = s1_left_reg;
            best_top_next    = s1_top_reg;
            best_right_next  = s1_right_reg;
            best_bottom_next = s1_bottom_reg;
        end
        else
        begin
            best_left_next   = best_left_reg;
            best_top_next    = best_top_reg;
            best_right_next  = best_right_reg;
            best_bottom_next = best_bottom_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mid_list_reg  <= 1'b0;
            have_best_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            mid_list_reg  <= !s1_last_reg;
            have_best_reg <= have_next && !s1_last_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            center_x_reg    <= eff_cx;
            center_y_reg    <= eff_cy;
            anchor_x_reg    <= eff_ax;
            best_left_reg   <= best_left_next;
            best_top_reg    <= best_top_next;
            best_right_reg  <= best_right_next;
            best_bottom_reg <= best_bottom_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (rsp_load)
        begin
            rsp_valid_reg <= s1_adv && s1_last_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rsp_load && s1_adv && s1_last_reg)
        begin
            found_reg      <= have_next;
            sel_left_reg   <= have_next ? best_left_next   : '0;
            sel_top_reg    <= have_next ? best_top_next    : '0;
            sel_right_reg  <= have_next ? best_right_next  : '0;
            sel_bottom_reg <= have_next ? best_bottom_next : '0;
        end
    end

    assign rsp_valid  = rsp_valid_reg;
    assign found      = found_reg;
    assign sel_left   = sel_left_reg;
    assign sel_top    = sel_top_reg;
    assign sel_right  = sel_right_reg;
    assign sel_bottom = sel_bottom_reg;

endmodule

>>> bench/nearest_left_checker.sv
module nearest_left_checker #(
    parameter int CW = bhsnl_pkg::COORD_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    input  logic          req_stall,
    input  logic [CW-1:0] point_a_x,
    input  logic [CW-1:0] point_a_y,
    input  logic [CW-1:0] point_b_x,
    input  logic [CW-1:0] point_b_y,
    input  logic [CW-1:0] rect_left,
    input  logic [CW-1:0] rect_top,
    input  logic [CW-1:0] rect_right,
    input  logic [CW-1:0] rect_bottom,
    input  logic          rect_present,
    input  logic          last_rect,
    input  logic          rsp_valid,
    input  logic          rsp_stall,
    input  logic          found,
    input  logic [CW-1:0] sel_left,
    input  logic [CW-1:0] sel_top,
    input  logic [CW-1:0] sel_right,
    input  logic [CW-1:0] sel_bottom,
    output int            mismatches,
    output int            lists_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic          found;
        logic [CW-1:0] left;
        logic [CW-1:0] top;
        logic [CW-1:0] right;
        logic [CW-1:0] bottom;
    } box_pick_t;

    // Shadow state of the list scan
    logic          in_list   = 1'b0;
    logic [CW-1:0] mid_x     = '0;
    logic [CW-1:0] mid_y     = '0;
    logic [CW-1:0] anchor_ax = '0;
    logic          have_pick = 1'b0;
    logic [CW-1:0] kept_l    = '0;
    logic [CW-1:0] kept_t    = '0;
    logic [CW-1:0] kept_r    = '0;
    logic [CW-1:0] kept_b    = '0;

    box_pick_t picks_due[$];

    initial
    begin
        mismatches    = 0;
        lists_pending = 0;
    end

    task automatic report_mismatch(input string what, input int want, input int got);
        mismatches++;
        if (mismatches <= 40)
        begin
            $display("%0t ns: %s mismatch: expected %0d, got %0d", $time, what, want, got);
        end
    endtask

    // Work out the effect of one accepted request on the running choice
    task automatic predict_pick();
        logic [CW:0] sum_x;
        logic [CW:0] sum_y;
        logic        hit;
        logic        take;
        int          dk;
        int          dn;
        box_pick_t   p;

        // first request of a list latches the points, midpoint rounds down
        if (!in_list)
        begin
            sum_x     = {1'b0, point_a_x} + {1'b0, point_b_x};
            sum_y     = {1'b0, point_a_y} + {1'b0, point_b_y};
            mid_x     = sum_x[CW:1];
            mid_y     = sum_y[CW:1];
            anchor_ax = point_a_x;
            have_pick = 1'b0;
        end

        hit = rect_present && rect_left <= mid_x && rect_right >= mid_x
              && rect_top <= mid_y && rect_bottom >= mid_y;

        if (hit)
        begin
            dk = int'(anchor_ax) - int'(kept_l);
            dn = int'(anchor_ax) - int'(rect_left);
            if (!have_pick || dk < 0)
                take = 1'b1;
            else if (dn < 0)
                take = 1'b0;
            else
                take = !(dk < dn);   // tie goes to the later box
            if (take)
            begin
                kept_l    = rect_left;
                kept_t    = rect_top;
                kept_r    = rect_right;
                kept_b    = rect_bottom;
                have_pick = 1'b1;
            end
        end

        if (last_rect)
        begin
            p.found  = have_pick;
            p.left   = have_pick ? kept_l : '0;
            p.top    = have_pick ? kept_t : '0;
            p.right  = have_pick ? kept_r : '0;
            p.bottom = have_pick ? kept_b : '0;
            picks_due = {picks_due, p};
            in_list   = 1'b0;
            have_pick = 1'b0;
            kept_l    = '0;
            kept_t    = '0;
            kept_r    = '0;
            kept_b    = '0;
        end
        else
        begin
            in_list = 1'b1;
        end
    endtask

    // Responses are checked before the request of the same edge is predicted
    always @(posedge clk)
    begin
        box_pick_t want;
        if (rst_n)
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (picks_due.size() == 0)
                begin
                    report_mismatch("lists pending at response", 1, 0);
                end
                else
                begin
                    want = picks_due.pop_front();
                    if (found !== want.found)
                        report_mismatch("found", int'(want.found), int'(found));
                    if (sel_left !== want.left)
                        report_mismatch("sel_left", int'(want.left), int'(sel_left));
                    if (sel_top !== want.top)
                        report_mismatch("sel_top", int'(want.top), int'(sel_top));
                    if (sel_right !== want.right)
                        report_mismatch("sel_right", int'(want.right), int'(sel_right));
                    if (sel_bottom !== want.bottom)
                        report_mismatch("sel_bottom", int'(want.bottom), int'(sel_bottom));
                end
            end
            if (req_valid && !req_stall)
            begin
                predict_pick();
            end
            lists_pending = picks_due.size();
        end
    end

endmodule

>>> bench/tb_box_hit_select_nearest_left_top.sv
module tb_box_hit_select_nearest_left_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CW   = bhsnl_pkg::COORD_BITS_DEF;
    localparam int CMAX = (1 << CW) - 1;

    typedef logic [CW-1:0] coord_t;

    typedef struct packed {
        coord_t ax;
        coord_t ay;
        coord_t bx;
        coord_t by;
        coord_t left;
        coord_t top;
        coord_t right;
        coord_t bottom;
        logic   present;
        logic   last;
    } box_req_t;

    logic   clk = 1'b0;
    logic   rst_n;
    logic   req_valid;
    logic   req_stall;
    coord_t point_a_x;
    coord_t point_a_y;
    coord_t point_b_x;
    coord_t point_b_y;
    coord_t rect_left;
    coord_t rect_top;
    coord_t rect_right;
    coord_t rect_bottom;
    logic   rect_present;
    logic   last_rect;
    logic   rsp_valid;
    logic   rsp_stall;
    logic   found;
    coord_t sel_left;
    coord_t sel_top;
    coord_t sel_right;
    coord_t sel_bottom;
    int     mismatches;
    int     lists_pending;

    // Idle rates in percent, and a token that starts a long response hold-off
    int send_idle_pct = 34;
    int rcv_idle_pct  = 79;
    int hold_token    = 0;

    box_hit_select_nearest_left_top dut (.*);

    nearest_left_checker chk (.*);

    always #1 clk = ~clk;

    // Run limit
    initial
    begin
        #400_000;
        $display("box_hit_select_nearest_left_top verification failed");
        $finish;
    end

    // Response side: random stalls, plus a counted hold-off on request
    initial
    begin
        int hold_seen;
        int hold_left;
        hold_seen = 0;
        hold_left = 0;
        rsp_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_token != hold_seen)
            begin
                hold_seen = hold_token;
                hold_left = 80;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_stall <= 1'b1;
            end
            else
            begin
                rsp_stall <= ($urandom_range(0, 99) < rcv_idle_pct);
            end
        end
    end

    function automatic int clamp_coord(input int v);
        return (v < 0) ? 0 : ((v > CMAX) ? CMAX : v);
    endfunction

    function automatic box_req_t mk_req(input int ax, input int ay, input int bx, input int by,
                                        input int l, input int t, input int r, input int b,
                                        input int present, input int last);
        box_req_t q;
        q.ax      = coord_t'(ax);
        q.ay      = coord_t'(ay);
        q.bx      = coord_t'(bx);
        q.by      = coord_t'(by);
        q.left    = coord_t'(l);
        q.top     = coord_t'(t);
        q.right   = coord_t'(r);
        q.bottom  = coord_t'(b);
        q.present = (present != 0);
        q.last    = (last != 0);
        return q;
    endfunction

    // Offer one request and hold it until accepted; called at a rising edge
    task automatic push_request(input box_req_t q);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid    <= 1'b1;
        point_a_x    <= q.ax;
        point_a_y    <= q.ay;
        point_b_x    <= q.bx;
        point_b_y    <= q.by;
        rect_left    <= q.left;
        rect_top     <= q.top;
        rect_right   <= q.right;
        rect_bottom  <= q.bottom;
        rect_present <= q.present;
        last_rect    <= q.last;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
    endtask

    // Sender goes quiet until every pending list has answered
    task automatic pause_until_drained(input int s_pct, input int r_pct, input bit long_hold);
        req_valid <= 1'b0;
        do
            @(negedge clk);
        while (lists_pending != 0);
        send_idle_pct = s_pct;
        rcv_idle_pct  = r_pct;
        @(posedge clk);
        if (long_hold)
            hold_token <= hold_token + 1;
    endtask

    // Random lists, mostly boxes placed around the midpoint
    task automatic send_random_lists(input int n_items);
        box_req_t q;
        int sent, len, k, kind;
        int ax, ay, bx, by, cx, cy;
        sent = 0;
        while (sent < n_items)
        begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 14) : $urandom_range(1, 4);
            ax  = $urandom_range(0, CMAX);
            ay  = $urandom_range(0, CMAX);
            by  = $urandom_range(0, CMAX);
            // B close to A puts A.x near the midpoint, so both signs of the
            // left-edge distance come up
            if ($urandom_range(0, 1))
                bx = clamp_coord(ax + $urandom_range(0, 16) - 8);
            else
                bx = $urandom_range(0, CMAX);
            cx = (ax + bx) / 2;
            cy = (ay + by) / 2;
            for (k = 0; k < len; k++)
            begin
                // points only matter on the first request of a list
                q.ax      = coord_t'((k == 0) ? ax : $urandom_range(0, CMAX));
                q.ay      = coord_t'((k == 0) ? ay : $urandom_range(0, CMAX));
                q.bx      = coord_t'((k == 0) ? bx : $urandom_range(0, CMAX));
                q.by      = coord_t'((k == 0) ? by : $urandom_range(0, CMAX));
                q.present = ($urandom_range(0, 11) != 0);
                q.last    = (k == len - 1);
                kind      = $urandom_range(0, 9);
                if (kind < 6)
                begin
                    q.left   = coord_t'(clamp_coord(cx - (($urandom_range(0, 3) == 0) ?
                                           $urandom_range(0, CMAX) : $urandom_range(0, 7))));
                    q.right  = coord_t'(clamp_coord(cx + $urandom_range(0, 4000)));
                    q.top    = coord_t'(clamp_coord(cy - $urandom_range(0, 60)));
                    q.bottom = coord_t'(clamp_coord(cy + $urandom_range(0, 60)));
                end
                else if (kind == 6)
                begin
                    // edges on or one off the midpoint
                    q.left   = coord_t'(clamp_coord(cx + $urandom_range(0, 2) - 1));
                    q.right  = coord_t'(clamp_coord(cx + $urandom_range(0, 2) - 1));
                    q.top    = coord_t'(clamp_coord(cy + $urandom_range(0, 2) - 1));
                    q.bottom = coord_t'(clamp_coord(cy + $urandom_range(0, 2) - 1));
                end
                else if (kind == 7)
                begin
                    // inverted in x
                    q.left   = coord_t'(clamp_coord(cx + 1 + $urandom_range(0, 20)));
                    q.right  = coord_t'(clamp_coord(cx - $urandom_range(0, 20)));
                    q.top    = coord_t'(clamp_coord(cy - $urandom_range(0, 60)));
                    q.bottom = coord_t'(clamp_coord(cy + $urandom_range(0, 60)));
                end
                else
                begin
                    q.left   = coord_t'($urandom_range(0, CMAX));
                    q.right  = coord_t'($urandom_range(0, CMAX));
                    q.top    = coord_t'($urandom_range(0, CMAX));
                    q.bottom = coord_t'($urandom_range(0, CMAX));
                end
                push_request(q);
                sent++;
            end
        end
    endtask

    // Stimulus and verdict
    initial
    begin
        rst_n        <= 1'b0;
        req_valid    <= 1'b0;
        point_a_x    <= '0;
        point_a_y    <= '0;
        point_b_x    <= '0;
        point_b_y    <= '0;
        rect_left    <= '0;
        rect_top     <= '0;
        rect_right   <= '0;
        rect_bottom  <= '0;
        rect_present <= 1'b0;
        last_rect    <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // empty list, then single-request lists, most at the coordinate extremes
        push_request(mk_req(CMAX, CMAX, CMAX, CMAX, 0, 0, 0, 0, 0, 1));
        push_request(mk_req(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, 1, 1));
        push_request(mk_req(0, 0, 0, 0, 0, 0, 0, 0, 1, 1));
        push_request(mk_req(100, 100, 200, 200, 151, 0, 200, 300, 1, 1));
        push_request(mk_req(CMAX, 0, 0, CMAX, 0, 0, CMAX, CMAX, 1, 1));
        // first request without a box still latches the points; smaller
        // distance wins, ties go to the later box, inverted box never hits
        push_request(mk_req(1000, 500, 1001, 501, 0, 0, CMAX, CMAX, 0, 0));
        push_request(mk_req(0, 0, 0, 0, 990, 490, 1010, 510, 1, 0));
        push_request(mk_req(5, 5, 5, 5, 1010, 490, 990, 510, 1, 0));
        push_request(mk_req(0, 0, 0, 0, 995, 490, 1010, 510, 1, 0));
        push_request(mk_req(0, 0, 0, 0, 995, 490, 1020, 510, 1, 0));
        push_request(mk_req(0, 0, 0, 0, 980, 490, 1030, 510, 1, 0));
        push_request(mk_req(0, 0, 0, 0, 0, 0, CMAX, CMAX, 0, 1));
        // kept left beyond A.x is always replaced; new left beyond A.x loses
        push_request(mk_req(100, 50, 300, 50, 150, 0, 250, 100, 1, 0));
        push_request(mk_req(0, 0, 0, 0, 160, 0, 250, 100, 1, 0));
        push_request(mk_req(0, 0, 0, 0, 90, 0, 250, 100, 1, 0));
        push_request(mk_req(0, 0, 0, 0, 120, 0, 250, 100, 1, 0));
        push_request(mk_req(0, 0, 0, 0, 95, 0, 250, 100, 1, 0));
        push_request(mk_req(0, 0, 0, 0, 200, 50, 200, 50, 1, 1));

        send_random_lists(250);
        pause_until_drained(79, 34, 1'b0);
        send_random_lists(250);
        // no idling; the response side first holds off long enough to back up
        pause_until_drained(0, 0, 1'b1);
        send_random_lists(250);
        pause_until_drained(0, 0, 1'b0);
        repeat (6) @(posedge clk);

        if (mismatches == 0)
            $display("box_hit_select_nearest_left_top verification clean");
        else
            $display("box_hit_select_nearest_left_top verification failed");
        $finish;
    end

endmodule
